// ===== rtl/srctok_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// srctok_pkg: shared types and constants of the source tokenizer
// Word formats of both channels, token kind codes, character classes and the
// keyword table used to classify finished identifiers.
// ----------------------------------------------------------------------------
package srctok_pkg;

    localparam int LINE_BITS   = 16;
    localparam int COLUMN_BITS = 12;
    localparam int OFFSET_BITS = 24;
    localparam int LENGTH_BITS = 12;
    localparam int KIND_BITS   = 5;
    localparam int KW_DEPTH    = 9;
    localparam int KW_COUNT    = 4;

    // Token kind codes
    localparam logic [KIND_BITS-1:0] KIND_LBRACE     = 5'd0;
    localparam logic [KIND_BITS-1:0] KIND_RBRACE     = 5'd1;
    localparam logic [KIND_BITS-1:0] KIND_LPAREN     = 5'd2;
    localparam logic [KIND_BITS-1:0] KIND_RPAREN     = 5'd3;
    localparam logic [KIND_BITS-1:0] KIND_SEMICOLON  = 5'd4;
    localparam logic [KIND_BITS-1:0] KIND_DOT        = 5'd5;
    localparam logic [KIND_BITS-1:0] KIND_EQUALS     = 5'd6;
    localparam logic [KIND_BITS-1:0] KIND_COLONCOLON = 5'd7;
    localparam logic [KIND_BITS-1:0] KIND_ARROW      = 5'd8;
    localparam logic [KIND_BITS-1:0] KIND_NAMESPACE  = 5'd9;
    localparam logic [KIND_BITS-1:0] KIND_IDENT      = 5'd13;
    localparam logic [KIND_BITS-1:0] KIND_INTEGER    = 5'd14;
    localparam logic [KIND_BITS-1:0] KIND_UNKNOWN    = 5'd15;
    localparam logic [KIND_BITS-1:0] KIND_EOF        = 5'd16;

    // Characters with a role of their own
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_GT    = 8'h3E;

    // Keywords, in kind order starting at KIND_NAMESPACE
    localparam logic [7:0] KW_TEXT [KW_COUNT][KW_DEPTH] = '{
        '{"n", "a", "m", "e", "s", "p", "a", "c", "e"},
        '{"f", "n", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"r", "e", "t", "u", "r", "n", 8'h00, 8'h00, 8'h00},
        '{"i", "n", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    };
    localparam int KW_LEN [KW_COUNT] = '{9, 2, 6, 3};

    typedef struct packed {
        logic [7:0] char_byte;
        logic       end_of_source;
    } in_t;

    typedef struct packed {
        logic [KIND_BITS-1:0]   token_kind;
        logic [LINE_BITS-1:0]   start_line;
        logic [COLUMN_BITS-1:0] start_column;
        logic [OFFSET_BITS-1:0] start_offset;
        logic [LENGTH_BITS-1:0] token_length;
        logic [7:0]             unknown_char;
        logic                   last_of_run;
    } out_t;

    typedef enum logic [6:0] {
        MODE_IDLE    = 7'b0000001,
        MODE_SLASH   = 7'b0000010,
        MODE_COLON   = 7'b0000100,
        MODE_DASH    = 7'b0001000,
        MODE_IDENT   = 7'b0010000,
        MODE_NUMBER  = 7'b0100000,
        MODE_COMMENT = 7'b1000000
    } mode_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
    endfunction

    // Single-character punctuation: returns a hit flag and the kind.
    function automatic logic [KIND_BITS:0] punct_kind(input logic [7:0] c);
        logic [KIND_BITS:0] res;
        res = {1'b1, KIND_LBRACE};
        unique case (c)
            "{":     res = {1'b1, KIND_LBRACE};
            "}":     res = {1'b1, KIND_RBRACE};
            "(":     res = {1'b1, KIND_LPAREN};
            ")":     res = {1'b1, KIND_RPAREN};
            ";":     res = {1'b1, KIND_SEMICOLON};
            ".":     res = {1'b1, KIND_DOT};
            "=":     res = {1'b1, KIND_EQUALS};
            default: res = {1'b0, KIND_UNKNOWN};
        endcase
        return res;
    endfunction

    // Only the first len bytes of the buffer take part in the comparison.
    function automatic logic [KIND_BITS-1:0] ident_kind(
        input logic [KW_DEPTH-1:0][7:0] buffer,
        input logic [LENGTH_BITS-1:0]   len
    );
        logic [KIND_BITS-1:0] kind;
        logic                 hit;
        kind = KIND_IDENT;
        for (int k = 0; k < KW_COUNT; k++) begin
            hit = (len == LENGTH_BITS'(KW_LEN[k]));
            for (int i = 0; i < KW_DEPTH; i++) begin
                if ((i < KW_LEN[k]) && (buffer[i] != KW_TEXT[k][i])) begin
                    hit = 1'b0;
                end
            end
            if (hit) begin
                kind = KIND_NAMESPACE + KIND_BITS'(k);
            end
        end
        return kind;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/source_tokenizer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// source_tokenizer: streaming lexer, one source character per word
// Tracks line, column and byte offset, skips blanks and line comments, and
// emits one token word per recognised token with its kind, start and length.
// ----------------------------------------------------------------------------
// Usage. The s_ channel takes one word per source character, or an end word
// (end_of_source set) that flushes any pending token and yields an end-of-file
// token. The m_ channel delivers token words; last_of_run marks the final token
// caused by one input word. A word causes zero, one or two tokens.
// A token is registered into the token queue when the word that completes it
// is accepted, and m_ shows the head of the queue. Throughput: one input word
// per cycle while s_ready is high; the decision for each word is made by
// shallow character comparisons between the input and the pending-token state.
// A word that yields two tokens writes both into the queue at once, while m_
// hands tokens out one at a time, so a run of such words fills the queue.
// The four-word token queue decouples the two sides: s_ready is high while at
// least two entries are free, so input keeps flowing while a token waits for
// the receiver. When the receiver stalls, tokens build up in the queue and
// s_ready falls once fewer than two entries remain.
// Reset empties the queue, returns the scanner to idle and sets the position
// to line 1, column 1, offset 0. Position counters saturate at their maximum.
// ----------------------------------------------------------------------------
module source_tokenizer (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  s_valid,
    output logic                 s_ready,
    input  wire srctok_pkg::in_t s_data,
    output logic                 m_valid,
    input  wire                  m_ready,
    output srctok_pkg::out_t     m_data
);

    localparam int Q_DEPTH     = 4;
    localparam int Q_PTR_BITS  = $clog2(Q_DEPTH);
    localparam int KW_ADR_BITS = $clog2(srctok_pkg::KW_DEPTH);

    localparam logic [srctok_pkg::LINE_BITS-1:0]   LINE_MAX = '1;
    localparam logic [srctok_pkg::COLUMN_BITS-1:0] COL_MAX  = '1;
    localparam logic [srctok_pkg::OFFSET_BITS-1:0] OFF_MAX  = '1;
    localparam logic [srctok_pkg::LENGTH_BITS-1:0] LEN_MAX  = '1;

    // Scanner state
    srctok_pkg::mode_t mode_reg, mode_next;
    logic [srctok_pkg::LINE_BITS-1:0]   cur_line_reg, cur_line_next;
    logic [srctok_pkg::COLUMN_BITS-1:0] cur_col_reg, cur_col_next;
    logic [srctok_pkg::OFFSET_BITS-1:0] cur_off_reg, cur_off_next;
    logic [srctok_pkg::LINE_BITS-1:0]   tok_line_reg, tok_line_next;
    logic [srctok_pkg::COLUMN_BITS-1:0] tok_col_reg, tok_col_next;
    logic [srctok_pkg::OFFSET_BITS-1:0] tok_off_reg, tok_off_next;
    logic [srctok_pkg::LENGTH_BITS-1:0] plen_reg, plen_next;
    logic [srctok_pkg::KW_DEPTH-1:0][7:0] kw_buf_reg;

    // Keyword buffer write port
    logic                   kw_we;
    logic [KW_ADR_BITS-1:0] kw_waddr;

    // Token queue
    srctok_pkg::out_t q_entry_reg [Q_DEPTH];
    logic [Q_PTR_BITS-1:0] q_wr_reg, q_wr_next;
    logic [Q_PTR_BITS-1:0] q_rd_reg, q_rd_next;
    logic [Q_PTR_BITS:0]   q_count_reg, q_count_next;

    logic       accept;
    logic       deq;
    logic [7:0] c;
    logic       eos;
    logic       consumed;

    // Pending token (A, at the saved start) and character token (B, at the
    // current position). A always precedes B.
    logic                               fl_valid;
    logic [srctok_pkg::KIND_BITS-1:0]   fl_kind;
    logic [srctok_pkg::LENGTH_BITS-1:0] fl_len;
    logic [7:0]                         fl_char;
    logic                               a_valid;
    logic [srctok_pkg::KIND_BITS-1:0]   a_kind;
    logic [srctok_pkg::LENGTH_BITS-1:0] a_len;
    logic [7:0]                         a_char;
    logic                               b_valid;
    logic [srctok_pkg::KIND_BITS-1:0]   b_kind;
    logic [srctok_pkg::LENGTH_BITS-1:0] b_len;
    logic [7:0]                         b_char;
    logic [srctok_pkg::KIND_BITS:0]     punct;

    srctok_pkg::out_t tok_a;
    srctok_pkg::out_t tok_b;
    srctok_pkg::out_t first_word;
    logic [1:0]       n_enq;

    assign c       = s_data.char_byte;
    assign eos     = s_data.end_of_source;
    assign s_ready = (q_count_reg <= (Q_PTR_BITS + 1)'(Q_DEPTH - 2));
    assign accept  = s_valid && s_ready;
    assign m_valid = (q_count_reg != '0);
    assign deq     = m_valid && m_ready;
    assign m_data  = q_entry_reg[q_rd_reg];
    assign punct   = srctok_pkg::punct_kind(c);

    // What the pending token becomes if it is cut off here.
    always_comb begin
        fl_valid = 1'b1;
        fl_kind  = srctok_pkg::KIND_UNKNOWN;
        fl_len   = srctok_pkg::LENGTH_BITS'(1);
        fl_char  = 8'h00;
        unique case (mode_reg)
            srctok_pkg::MODE_IDENT: begin
                fl_kind = srctok_pkg::ident_kind(kw_buf_reg, plen_reg);
                fl_len  = plen_reg;
            end
            srctok_pkg::MODE_NUMBER: begin
                fl_kind = srctok_pkg::KIND_INTEGER;
                fl_len  = plen_reg;
            end
            srctok_pkg::MODE_COLON: fl_char = srctok_pkg::CH_COLON;
            srctok_pkg::MODE_DASH:  fl_char = srctok_pkg::CH_DASH;
            srctok_pkg::MODE_SLASH: fl_char = srctok_pkg::CH_SLASH;
            default:                fl_valid = 1'b0;
        endcase
    end

    // Position advance: every character word moves the position once.
    always_comb begin
        cur_line_next = cur_line_reg;
        cur_col_next  = cur_col_reg;
        cur_off_next  = cur_off_reg;
        if (!eos) begin
            cur_off_next = (cur_off_reg != OFF_MAX) ? cur_off_reg + 1'b1 : OFF_MAX;
            if (c == srctok_pkg::CH_LF) begin
                cur_line_next = (cur_line_reg != LINE_MAX) ? cur_line_reg + 1'b1 : LINE_MAX;
                cur_col_next  = srctok_pkg::COLUMN_BITS'(1);
            end else begin
                cur_col_next = (cur_col_reg != COL_MAX) ? cur_col_reg + 1'b1 : COL_MAX;
            end
        end
    end

    // Scanner decision for one word.
    always_comb begin
        mode_next     = mode_reg;
        plen_next     = plen_reg;
        tok_line_next = tok_line_reg;
        tok_col_next  = tok_col_reg;
        tok_off_next  = tok_off_reg;
        kw_we         = 1'b0;
        kw_waddr      = '0;
        consumed      = 1'b0;
        a_valid       = 1'b0;
        a_kind        = fl_kind;
        a_len         = fl_len;
        a_char        = fl_char;
        b_valid       = 1'b0;
        b_kind        = srctok_pkg::KIND_UNKNOWN;
        b_len         = srctok_pkg::LENGTH_BITS'(1);
        b_char        = 8'h00;

        if (eos) begin
            // Flush, then end of file at the current position.
            a_valid   = fl_valid;
            b_valid   = 1'b1;
            b_kind    = srctok_pkg::KIND_EOF;
            b_len     = '0;
            mode_next = srctok_pkg::MODE_IDLE;
        end else begin
            unique case (mode_reg)
                srctok_pkg::MODE_IDENT: begin
                    if (srctok_pkg::is_alpha(c) || srctok_pkg::is_digit(c)) begin
                        consumed = 1'b1;
                        if (plen_reg < srctok_pkg::LENGTH_BITS'(srctok_pkg::KW_DEPTH)) begin
                            kw_we    = 1'b1;
                            kw_waddr = plen_reg[KW_ADR_BITS-1:0];
                        end
                        plen_next = (plen_reg != LEN_MAX) ? plen_reg + 1'b1 : LEN_MAX;
                    end
                end
                srctok_pkg::MODE_NUMBER: begin
                    if (srctok_pkg::is_digit(c)) begin
                        consumed  = 1'b1;
                        plen_next = (plen_reg != LEN_MAX) ? plen_reg + 1'b1 : LEN_MAX;
                    end
                end
                srctok_pkg::MODE_COMMENT: begin
                    consumed = (c != srctok_pkg::CH_LF);
                end
                srctok_pkg::MODE_COLON: begin
                    if (c == srctok_pkg::CH_COLON) begin
                        consumed  = 1'b1;
                        a_valid   = 1'b1;
                        a_kind    = srctok_pkg::KIND_COLONCOLON;
                        a_len     = srctok_pkg::LENGTH_BITS'(2);
                        a_char    = 8'h00;
                        mode_next = srctok_pkg::MODE_IDLE;
                    end
                end
                srctok_pkg::MODE_DASH: begin
                    if (c == srctok_pkg::CH_GT) begin
                        consumed  = 1'b1;
                        a_valid   = 1'b1;
                        a_kind    = srctok_pkg::KIND_ARROW;
                        a_len     = srctok_pkg::LENGTH_BITS'(2);
                        a_char    = 8'h00;
                        mode_next = srctok_pkg::MODE_IDLE;
                    end
                end
                srctok_pkg::MODE_SLASH: begin
                    if (c == srctok_pkg::CH_SLASH) begin
                        consumed  = 1'b1;
                        mode_next = srctok_pkg::MODE_COMMENT;
                    end
                end
                default: begin
                end
            endcase

            if (!consumed) begin
                // The pending token ends here and the character is lexed afresh.
                a_valid   = fl_valid;
                mode_next = srctok_pkg::MODE_IDLE;
                priority if (srctok_pkg::is_blank(c)) begin
                end else if (punct[srctok_pkg::KIND_BITS]) begin
                    b_valid = 1'b1;
                    b_kind  = punct[srctok_pkg::KIND_BITS-1:0];
                end else if ((c == srctok_pkg::CH_SLASH) || (c == srctok_pkg::CH_COLON)
                             || (c == srctok_pkg::CH_DASH)) begin
                    tok_line_next = cur_line_reg;
                    tok_col_next  = cur_col_reg;
                    tok_off_next  = cur_off_reg;
                    plen_next     = srctok_pkg::LENGTH_BITS'(1);
                    if (c == srctok_pkg::CH_SLASH) begin
                        mode_next = srctok_pkg::MODE_SLASH;
                    end else if (c == srctok_pkg::CH_COLON) begin
                        mode_next = srctok_pkg::MODE_COLON;
                    end else begin
                        mode_next = srctok_pkg::MODE_DASH;
                    end
                end else if (srctok_pkg::is_alpha(c)) begin
                    tok_line_next = cur_line_reg;
                    tok_col_next  = cur_col_reg;
                    tok_off_next  = cur_off_reg;
                    plen_next     = srctok_pkg::LENGTH_BITS'(1);
                    kw_we         = 1'b1;
                    kw_waddr      = '0;
                    mode_next     = srctok_pkg::MODE_IDENT;
                end else if (srctok_pkg::is_digit(c)) begin
                    tok_line_next = cur_line_reg;
                    tok_col_next  = cur_col_reg;
                    tok_off_next  = cur_off_reg;
                    plen_next     = srctok_pkg::LENGTH_BITS'(1);
                    mode_next     = srctok_pkg::MODE_NUMBER;
                end else begin
                    b_valid = 1'b1;
                    b_char  = c;
                end
            end
        end
    end

    // Assemble the token words. When both are present, A comes first and
    // only B carries last_of_run.
    always_comb begin
        tok_a.token_kind   = a_kind;
        tok_a.start_line   = tok_line_reg;
        tok_a.start_column = tok_col_reg;
        tok_a.start_offset = tok_off_reg;
        tok_a.token_length = a_len;
        tok_a.unknown_char = a_char;
        tok_a.last_of_run  = !b_valid;

        tok_b.token_kind   = b_kind;
        tok_b.start_line   = cur_line_reg;
        tok_b.start_column = cur_col_reg;
        tok_b.start_offset = cur_off_reg;
        tok_b.token_length = b_len;
        tok_b.unknown_char = b_char;
        tok_b.last_of_run  = 1'b1;

        first_word = a_valid ? tok_a : tok_b;
        n_enq      = accept ? ({1'b0, a_valid} + {1'b0, b_valid}) : 2'd0;

        q_wr_next    = q_wr_reg + Q_PTR_BITS'(n_enq);
        q_rd_next    = q_rd_reg + Q_PTR_BITS'(deq);
        q_count_next = q_count_reg + (Q_PTR_BITS + 1)'(n_enq) - (Q_PTR_BITS + 1)'(deq);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= srctok_pkg::MODE_IDLE;
            cur_line_reg <= srctok_pkg::LINE_BITS'(1);
            cur_col_reg  <= srctok_pkg::COLUMN_BITS'(1);
            cur_off_reg  <= '0;
            tok_line_reg <= srctok_pkg::LINE_BITS'(1);
            tok_col_reg  <= srctok_pkg::COLUMN_BITS'(1);
            tok_off_reg  <= '0;
            plen_reg     <= '0;
            q_wr_reg     <= '0;
            q_rd_reg     <= '0;
            q_count_reg  <= '0;
        end else begin
            if (accept) begin
                mode_reg     <= mode_next;
                cur_line_reg <= cur_line_next;
                cur_col_reg  <= cur_col_next;
                cur_off_reg  <= cur_off_next;
                tok_line_reg <= tok_line_next;
                tok_col_reg  <= tok_col_next;
                tok_off_reg  <= tok_off_next;
                plen_reg     <= plen_next;
            end
            q_wr_reg    <= q_wr_next;
            q_rd_reg    <= q_rd_next;
            q_count_reg <= q_count_next;
        end
    end

    // Payload storage: no reset needed.
    always_ff @(posedge aclk) begin
        if (accept && kw_we) begin
            kw_buf_reg[kw_waddr] <= c;
        end
        if (n_enq != 2'd0) begin
            q_entry_reg[q_wr_reg] <= first_word;
        end
        if (n_enq == 2'd2) begin
            q_entry_reg[q_wr_reg + 1'b1] <= tok_b;
        end
    end

`ifndef SYNTHESIS
    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_count_reg <= (Q_PTR_BITS + 1)'(Q_DEPTH))
        else $error("token queue overfilled");

    a_end_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && eos) |=> (mode_reg == srctok_pkg::MODE_IDLE))
        else $error("scanner not idle after end word");

    a_pending_length: assert property (@(posedge aclk) disable iff (!aresetn)
        ((mode_reg == srctok_pkg::MODE_IDENT) || (mode_reg == srctok_pkg::MODE_NUMBER))
        |-> (plen_reg != '0))
        else $error("pending identifier or number with zero length");

    a_position_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (cur_line_reg != '0) && (cur_col_reg != '0))
        else $error("line or column counter reached zero");
`endif

endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the source tokenizer
// Characters and end words are fed through the s_ channel while a scanner
// model kept in this file works out the tokens each accepted word should give.
// Every token word on the m_ channel is compared field by field with the
// oldest outstanding prediction. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;

    // Keyword kinds follow namespace in the order fn, return, int.
    localparam logic [srctok_pkg::KIND_BITS-1:0] KIND_FN     = srctok_pkg::KIND_NAMESPACE + 5'd1;
    localparam logic [srctok_pkg::KIND_BITS-1:0] KIND_RETURN = srctok_pkg::KIND_NAMESPACE + 5'd2;
    localparam logic [srctok_pkg::KIND_BITS-1:0] KIND_INT    = srctok_pkg::KIND_NAMESPACE + 5'd3;

    localparam int RANDOM_WORDS = 1650;  // rough size of the random part
    localparam int STALL_LIMIT  = 2000;  // cycles without any handshake
    localparam int LONG_HOLD    = 400;   // receiver hold-off under pressure
    localparam int TAIL_CYCLES  = 20;    // quiet time after the last token

    // Character pools for building random source text.
    localparam string ID_HEAD  = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
    localparam string ID_TAIL  = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
    localparam string PUNCT    = "{}();.=";
    localparam string BLANKS   = " \t\r\n";

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    srctok_pkg::in_t   s_data;
    logic              m_valid;
    logic              m_ready;
    srctok_pkg::out_t  m_data;

    source_tokenizer dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Scanner model. It mirrors the position counters, the pending-token
    // mode and the first nine characters of the identifier being built.
    // ------------------------------------------------------------------
    srctok_pkg::mode_t                  lex_mode;
    logic [srctok_pkg::LINE_BITS-1:0]   pos_line;
    logic [srctok_pkg::COLUMN_BITS-1:0] pos_col;
    logic [srctok_pkg::OFFSET_BITS-1:0] pos_off;
    logic [srctok_pkg::LINE_BITS-1:0]   tok_line;
    logic [srctok_pkg::COLUMN_BITS-1:0] tok_col;
    logic [srctok_pkg::OFFSET_BITS-1:0] tok_off;
    logic [srctok_pkg::LENGTH_BITS-1:0] tok_len;
    logic [7:0]                         kw_buf [srctok_pkg::KW_DEPTH];

    // Tokens predicted but not yet seen on the m_ channel, oldest first.
    srctok_pkg::out_t tokens_due [$];

    int   mismatches   = 0;
    int   words_sent   = 0;
    bit   no_idle      = 1'b0;  // when set, neither side inserts gaps
    int   hold_request = 0;     // asks the receiver for a long hold-off

    function automatic srctok_pkg::out_t token_word(
        input logic [srctok_pkg::KIND_BITS-1:0]   kind,
        input logic [srctok_pkg::LINE_BITS-1:0]   line,
        input logic [srctok_pkg::COLUMN_BITS-1:0] col,
        input logic [srctok_pkg::OFFSET_BITS-1:0] off,
        input logic [srctok_pkg::LENGTH_BITS-1:0] len,
        input logic [7:0]                         ch
    );
        srctok_pkg::out_t t;
        t.token_kind   = kind;
        t.start_line   = line;
        t.start_column = col;
        t.start_offset = off;
        t.token_length = len;
        t.unknown_char = ch;
        t.last_of_run  = 1'b0;
        return t;
    endfunction

    function automatic logic letter_byte(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic logic digit_byte(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    // Only the characters below the pending length have been written, and
    // each comparison looks at exactly that many of them.
    function automatic logic [srctok_pkg::KIND_BITS-1:0] keyword_kind();
        if (tok_len == 9 && {kw_buf[0], kw_buf[1], kw_buf[2], kw_buf[3], kw_buf[4],
                             kw_buf[5], kw_buf[6], kw_buf[7], kw_buf[8]} == "namespace")
            return srctok_pkg::KIND_NAMESPACE;
        if (tok_len == 2 && {kw_buf[0], kw_buf[1]} == "fn")
            return KIND_FN;
        if (tok_len == 6 && {kw_buf[0], kw_buf[1], kw_buf[2], kw_buf[3], kw_buf[4],
                             kw_buf[5]} == "return")
            return KIND_RETURN;
        if (tok_len == 3 && {kw_buf[0], kw_buf[1], kw_buf[2]} == "int")
            return KIND_INT;
        return srctok_pkg::KIND_IDENT;
    endfunction

    function automatic void advance(input logic [7:0] c);
        if (pos_off != '1) pos_off++;
        if (c == srctok_pkg::CH_LF) begin
            if (pos_line != '1) pos_line++;
            pos_col = srctok_pkg::COLUMN_BITS'(1);
        end else if (pos_col != '1) begin
            pos_col++;
        end
    endfunction

    function automatic void mark_start();
        tok_line = pos_line;
        tok_col  = pos_col;
        tok_off  = pos_off;
    endfunction

    function automatic void grow_token();
        if (tok_len != '1) tok_len++;
    endfunction

    // Closes whatever token is pending; returns 1 if that yields a token.
    function automatic logic flush_token(output srctok_pkg::out_t t);
        logic hit;
        hit = 1'b1;
        t   = '0;
        case (lex_mode)
            srctok_pkg::MODE_IDENT:
                t = token_word(keyword_kind(), tok_line, tok_col, tok_off, tok_len, 8'd0);
            srctok_pkg::MODE_NUMBER:
                t = token_word(srctok_pkg::KIND_INTEGER, tok_line, tok_col, tok_off,
                               tok_len, 8'd0);
            srctok_pkg::MODE_COLON:
                t = token_word(srctok_pkg::KIND_UNKNOWN, tok_line, tok_col, tok_off,
                               12'd1, srctok_pkg::CH_COLON);
            srctok_pkg::MODE_DASH:
                t = token_word(srctok_pkg::KIND_UNKNOWN, tok_line, tok_col, tok_off,
                               12'd1, srctok_pkg::CH_DASH);
            srctok_pkg::MODE_SLASH:
                t = token_word(srctok_pkg::KIND_UNKNOWN, tok_line, tok_col, tok_off,
                               12'd1, srctok_pkg::CH_SLASH);
            default: hit = 1'b0;
        endcase
        lex_mode = srctok_pkg::MODE_IDLE;
        return hit;
    endfunction

    function automatic void scanner_reset();
        lex_mode = srctok_pkg::MODE_IDLE;
        pos_line = srctok_pkg::LINE_BITS'(1);
        pos_col  = srctok_pkg::COLUMN_BITS'(1);
        pos_off  = '0;
        tok_line = srctok_pkg::LINE_BITS'(1);
        tok_col  = srctok_pkg::COLUMN_BITS'(1);
        tok_off  = '0;
        tok_len  = '0;
    endfunction

    // Works out the tokens one accepted word gives and queues them.
    task automatic lex_word(input srctok_pkg::in_t w);
        srctok_pkg::out_t                 found [2];
        srctok_pkg::out_t                 t;
        int                               n;
        logic [7:0]                       c;
        logic                             taken;
        logic                             is_punct;
        logic [srctok_pkg::KIND_BITS-1:0] pk;
        n     = 0;
        taken = 1'b0;
        c     = w.char_byte;
        if (w.end_of_source) begin
            // A pending comment is simply dropped; end of file keeps the position.
            if (flush_token(t)) begin
                found[n] = t;
                n++;
            end
            found[n] = token_word(srctok_pkg::KIND_EOF, pos_line, pos_col, pos_off, '0, 8'd0);
            n++;
        end else begin
            case (lex_mode)
                srctok_pkg::MODE_IDENT: begin
                    if (letter_byte(c) || digit_byte(c)) begin
                        if (tok_len < srctok_pkg::KW_DEPTH) kw_buf[tok_len[3:0]] = c;
                        grow_token();
                        advance(c);
                        taken = 1'b1;
                    end else if (flush_token(t)) begin
                        found[n] = t;
                        n++;
                    end
                end
                srctok_pkg::MODE_NUMBER: begin
                    if (digit_byte(c)) begin
                        grow_token();
                        advance(c);
                        taken = 1'b1;
                    end else if (flush_token(t)) begin
                        found[n] = t;
                        n++;
                    end
                end
                srctok_pkg::MODE_COMMENT: begin
                    // The newline that ends a comment is lexed as an ordinary blank.
                    if (c != srctok_pkg::CH_LF) begin
                        advance(c);
                        taken = 1'b1;
                    end else begin
                        lex_mode = srctok_pkg::MODE_IDLE;
                    end
                end
                srctok_pkg::MODE_COLON, srctok_pkg::MODE_DASH: begin
                    if ((lex_mode == srctok_pkg::MODE_COLON && c == srctok_pkg::CH_COLON) ||
                        (lex_mode == srctok_pkg::MODE_DASH && c == srctok_pkg::CH_GT)) begin
                        found[n] = token_word(lex_mode == srctok_pkg::MODE_COLON
                                                  ? srctok_pkg::KIND_COLONCOLON
                                                  : srctok_pkg::KIND_ARROW,
                                              tok_line, tok_col, tok_off, 12'd2, 8'd0);
                        n++;
                        lex_mode = srctok_pkg::MODE_IDLE;
                        advance(c);
                        taken = 1'b1;
                    end else if (flush_token(t)) begin
                        found[n] = t;
                        n++;
                    end
                end
                srctok_pkg::MODE_SLASH: begin
                    if (c == srctok_pkg::CH_SLASH) begin
                        lex_mode = srctok_pkg::MODE_COMMENT;
                        advance(c);
                        taken = 1'b1;
                    end else if (flush_token(t)) begin
                        found[n] = t;
                        n++;
                    end
                end
                default: lex_mode = srctok_pkg::MODE_IDLE;
            endcase

            // A character not absorbed by the pending token starts afresh.
            if (!taken) begin
                is_punct = 1'b1;
                pk       = srctok_pkg::KIND_LBRACE;
                case (c)
                    "{":     pk = srctok_pkg::KIND_LBRACE;
                    "}":     pk = srctok_pkg::KIND_RBRACE;
                    "(":     pk = srctok_pkg::KIND_LPAREN;
                    ")":     pk = srctok_pkg::KIND_RPAREN;
                    ";":     pk = srctok_pkg::KIND_SEMICOLON;
                    ".":     pk = srctok_pkg::KIND_DOT;
                    "=":     pk = srctok_pkg::KIND_EQUALS;
                    default: is_punct = 1'b0;
                endcase
                if (!(c == srctok_pkg::CH_SPACE || c == srctok_pkg::CH_TAB ||
                      c == srctok_pkg::CH_CR || c == srctok_pkg::CH_LF)) begin
                    if (is_punct) begin
                        found[n] = token_word(pk, pos_line, pos_col, pos_off, 12'd1, 8'd0);
                        n++;
                    end else if (c == srctok_pkg::CH_SLASH || c == srctok_pkg::CH_COLON ||
                                 c == srctok_pkg::CH_DASH) begin
                        mark_start();
                        tok_len = srctok_pkg::LENGTH_BITS'(1);
                        if (c == srctok_pkg::CH_SLASH) begin
                            lex_mode = srctok_pkg::MODE_SLASH;
                        end else if (c == srctok_pkg::CH_COLON) begin
                            lex_mode = srctok_pkg::MODE_COLON;
                        end else begin
                            lex_mode = srctok_pkg::MODE_DASH;
                        end
                    end else if (letter_byte(c)) begin
                        mark_start();
                        kw_buf[0] = c;
                        tok_len   = srctok_pkg::LENGTH_BITS'(1);
                        lex_mode  = srctok_pkg::MODE_IDENT;
                    end else if (digit_byte(c)) begin
                        mark_start();
                        tok_len  = srctok_pkg::LENGTH_BITS'(1);
                        lex_mode = srctok_pkg::MODE_NUMBER;
                    end else begin
                        found[n] = token_word(srctok_pkg::KIND_UNKNOWN, pos_line, pos_col,
                                              pos_off, 12'd1, c);
                        n++;
                    end
                end
                advance(c);
            end
        end

        for (int i = 0; i < n; i++) begin
            if (i == n - 1) found[i].last_of_run = 1'b1;
            tokens_due.insert(tokens_due.size(), found[i]);
        end
    endtask

    // ------------------------------------------------------------------
    // Gap lengths: mostly none or short, now and then a long one.
    // ------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // ------------------------------------------------------------------
    // Sender. Every call starts and ends just after a falling edge, so
    // s_valid and s_data only ever change there. Valid is lowered only
    // for a gap or by wait_drained, and it stays high across back-to-back words.
    // ------------------------------------------------------------------
    task automatic send_word(input srctok_pkg::in_t w);
        int gap;
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_data  <= w;
        s_valid <= 1'b1;
        // The word is taken at the first rising edge that sees ready high.
        do @(posedge aclk); while (!s_ready);
        lex_word(w);
        words_sent++;
        @(negedge aclk);
    endtask

    task automatic send_char(input logic [7:0] c);
        srctok_pkg::in_t w;
        w.char_byte     = c;
        w.end_of_source = 1'b0;
        send_word(w);
    endtask

    // The character field of an end word is ignored, so it carries noise.
    task automatic send_end();
        srctok_pkg::in_t w;
        w.char_byte     = 8'($urandom);
        w.end_of_source = 1'b1;
        send_word(w);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_char(s[i]);
    endtask

    // Holds the sender back until every predicted token has been seen.
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (tokens_due.size() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Receiver. It drives m_ready at the falling edge; a long hold-off
    // asked for by a test is counted down here, in this process alone.
    // ------------------------------------------------------------------
    initial begin
        int hold_left;
        int recv_gap;
        hold_left = 0;
        recv_gap  = 0;
        m_ready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else if (no_idle) begin
                m_ready <= 1'b1;
            end else if (recv_gap > 0) begin
                m_ready <= 1'b0;
                recv_gap--;
            end else begin
                m_ready  <= 1'b1;
                recv_gap = pick_gap();
            end
        end
    end

    // ------------------------------------------------------------------
    // Checker: each token word taken on the m_ channel is matched with
    // the oldest prediction, one field at a time.
    // ------------------------------------------------------------------
    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    srctok_pkg::out_t want_tok;

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (tokens_due.size() == 0) begin
                $display("%0t: token word with nothing outstanding, expected none, got %h",
                         $time, m_data);
                mismatches++;
            end else begin
                want_tok = tokens_due.pop_front();
                check_field("token_kind",   want_tok.token_kind,   m_data.token_kind);
                check_field("start_line",   want_tok.start_line,   m_data.start_line);
                check_field("start_column", want_tok.start_column, m_data.start_column);
                check_field("start_offset", want_tok.start_offset, m_data.start_offset);
                check_field("token_length", want_tok.token_length, m_data.token_length);
                check_field("unknown_char", want_tok.unknown_char, m_data.unknown_char);
                check_field("last_of_run",  want_tok.last_of_run,  m_data.last_of_run);
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: ends the run if no word moves on either channel for too
    // long. The longest legitimate silence is the receiver's hold-off.
    // ------------------------------------------------------------------
    initial begin
        int quiet;
        quiet = 0;
        @(posedge aresetn);
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet = 0;
            else quiet++;
        end
        $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset is held low and released at a falling edge.
    task automatic reset_dut();
        scanner_reset();
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
    endtask

    // Every punctuation mark and pair, a lone colon, dash and slash, bytes
    // that start no token, a keyword and an integer closed by end words,
    // a comment dropped by an end word, and the tab, CR and LF blanks.
    task automatic test_directed();
        send_text("{}();.=::->:-/");
        send_char(8'hFF);
        send_text("fn");
        send_end();
        send_text("7");
        send_end();
        send_text("//a");
        send_end();
        send_char(8'h00);
        send_text("\t\r\n");
        send_end();
    endtask

    // The receiver holds off for a long stretch while the sender offers
    // token-producing words back to back, so the token queue fills and
    // s_ready falls. The sender then waits until everything has drained.
    task automatic test_backpressure();
        no_idle      = 1'b1;
        hold_request = LONG_HOLD;
        repeat (60) begin
            if ($urandom_range(0, 3) == 0) send_text("::");
            else send_char(PUNCT[$urandom_range(0, PUNCT.len() - 1)]);
        end
        wait_drained();
        no_idle = 1'b0;
    endtask

    task automatic send_identifier(input int len);
        send_char(ID_HEAD[$urandom_range(0, ID_HEAD.len() - 1)]);
        for (int i = 1; i < len; i++)
            send_char(ID_TAIL[$urandom_range(0, ID_TAIL.len() - 1)]);
    endtask

    task automatic send_number(input int len);
        for (int i = 0; i < len; i++) send_char(8'("0" + $urandom_range(0, 9)));
    endtask

    // One fragment of plausible source text, or now and then noise.
    task automatic send_fragment();
        string near_words [12];
        int    r;
        int    len;
        near_words = '{"namespace", "fn", "return", "int", "namespac", "namespaces",
                       "f", "retur", "in", "intx", "Fn", "int_"};
        r = $urandom_range(0, 99);
        if (r < 15) begin
            send_text(near_words[$urandom_range(0, 11)]);
        end else if (r < 30) begin
            send_identifier($urandom_range(1, 12));
        end else if (r < 40) begin
            send_number($urandom_range(1, 6));
        end else if (r < 55) begin
            send_char(PUNCT[$urandom_range(0, PUNCT.len() - 1)]);
        end else if (r < 62) begin
            send_text($urandom_range(0, 1) ? "::" : "->");
        end else if (r < 68) begin
            // A comment whose body may hold any byte but a newline; some are
            // left open so that following text is swallowed.
            send_text("//");
            len = $urandom_range(0, 10);
            for (int i = 0; i < len; i++) begin
                r = $urandom_range(0, 255);
                send_char(r == srctok_pkg::CH_LF ? srctok_pkg::CH_SPACE : 8'(r));
            end
            if ($urandom_range(0, 9) < 6) send_char(srctok_pkg::CH_LF);
        end else if (r < 85) begin
            len = $urandom_range(1, 3);
            for (int i = 0; i < len; i++)
                send_char(BLANKS[$urandom_range(0, BLANKS.len() - 1)]);
        end else if (r < 95) begin
            send_char(8'($urandom_range(0, 255)));
        end else begin
            send_end();
        end
        // Tokens run together unless a blank often separates them.
        if ($urandom_range(0, 1) == 0) send_char(srctok_pkg::CH_SPACE);
    endtask

    // Mostly well-formed text with random content, in stretches with and
    // without gaps, with the occasional pause until all tokens are in.
    task automatic test_random_source();
        int first;
        first = words_sent;
        while (words_sent - first < RANDOM_WORDS) begin
            no_idle = (((words_sent - first) / 150) % 3) == 2;
            send_fragment();
            if ($urandom_range(0, 99) == 0) wait_drained();
        end
        no_idle = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Sequence of the run
    // ------------------------------------------------------------------
    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        reset_dut();
        test_directed();
        test_backpressure();
        test_random_source();
        // Let the last tokens arrive, then watch for any stray ones.
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0 && tokens_due.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
